@@ rtl/i2cm_pkg.sv @@
package i2cm_pkg;

  localparam logic [2:0]  LastBit         = 3'd7;
  localparam logic [14:0] AckTimeoutReset = 15'd100;
  localparam int          QueueDepth      = 2;

  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_STOP  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_WAIT  = 3'd3,
    MODE_READ  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_UNSTABLE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_ST_LOW  = 4'd1,
    PH_ST_END  = 4'd2,
    PH_SP_END  = 4'd3,
    PH_WR_HI   = 4'd4,
    PH_WR_LO   = 4'd5,
    PH_WR_END  = 4'd6,
    PH_WA_POLL = 4'd7,
    PH_WA_HIGH = 4'd8,
    PH_RD_HI   = 4'd9,
    PH_RD_LO   = 4'd10,
    PH_RD_TAIL = 4'd11,
    PH_RD_ACK  = 4'd12,
    PH_RD_REL  = 4'd13,
    PH_FIN     = 4'd14
  } phase_t;

  typedef struct packed {
    logic       cmd_ok;
    mode_t      mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

endpackage

@@ rtl/i2cm_front.sv @@
module i2cm_front
  import i2cm_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd_valid,
  input  logic [2:0] mode,
  input  logic [7:0] tx_byte,
  input  logic       send_ack,
  input  logic       sda_in,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastSlot = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCount = CW'(Depth);

  item_t         slots [Depth];
  item_t         item_in;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  always_comb begin
    item_in.cmd_ok   = cmd_valid && (mode <= 3'(MODE_READ));
    item_in.mode     = mode_t'(mode);
    item_in.tx_byte  = tx_byte;
    item_in.send_ack = send_ack;
    item_in.sda_in   = sda_in;
  end

  assign in_stall = (count == FullCount);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/i2cm_back.sv @@
module i2cm_back
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [14:0] cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic [1:0]  ack_status
);

  logic [14:0] ack_timeout;
  phase_t      phase, phase_next;
  mode_t       active, active_next;
  logic [2:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [14:0] poll_count, poll_count_next;
  logic        scl, scl_next;
  logic        sda, sda_next;
  logic        ack_choice, ack_choice_next;
  status_t     status, status_next;
  logic [7:0]  rx_hold, rx_hold_next;
  logic        done, done_next;
  logic        out_valid_next;

  assign q_pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    phase_next      = phase;
    active_next     = active;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    poll_count_next = poll_count;
    scl_next        = scl;
    sda_next        = sda;
    ack_choice_next = ack_choice;
    status_next     = status;
    rx_hold_next    = rx_hold;
    done_next       = done;
    out_valid_next  = out_valid && out_stall;
    if (q_pop) begin
      out_valid_next = 1'b1;
      done_next      = 1'b0;
      case (phase)
        PH_IDLE: begin
          if (q_item.cmd_ok) begin
            active_next    = q_item.mode;
            bit_index_next = LastBit;
            case (q_item.mode)
              MODE_START: begin
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                phase_next = PH_ST_LOW;
              end
              MODE_STOP: begin
                scl_next   = 1'b1;
                sda_next   = 1'b0;
                phase_next = PH_SP_END;
              end
              MODE_WRITE: begin
                shift_byte_next = q_item.tx_byte;
                scl_next        = 1'b0;
                sda_next        = q_item.tx_byte[LastBit];
                phase_next      = PH_WR_HI;
              end
              MODE_WAIT: begin
                poll_count_next = ack_timeout;
                phase_next      = PH_WA_POLL;
              end
              MODE_READ: begin
                shift_byte_next = '0;
                ack_choice_next = q_item.send_ack;
                scl_next        = 1'b0;
                phase_next      = PH_RD_HI;
              end
              default: ;
            endcase
          end
        end
        PH_ST_LOW: begin
          sda_next   = 1'b0;
          phase_next = PH_ST_END;
        end
        PH_ST_END: begin
          scl_next   = 1'b0;
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_SP_END: begin
          sda_next   = 1'b1;
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_WR_HI: begin
          scl_next = 1'b1;
          if (bit_index == '0) begin
            phase_next = PH_WR_END;
          end else begin
            bit_index_next = bit_index - 1'b1;
            phase_next     = PH_WR_LO;
          end
        end
        PH_WR_LO: begin
          scl_next   = 1'b0;
          sda_next   = shift_byte[bit_index];
          phase_next = PH_WR_HI;
        end
        PH_WR_END: begin
          scl_next   = 1'b0;
          sda_next   = 1'b1;
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        PH_WA_POLL: begin
          if (q_item.sda_in && (poll_count != '0)) begin
            poll_count_next = poll_count - 1'b1;
          end else if (poll_count == '0) begin
            status_next = ST_TIMEOUT;
            done_next   = 1'b1;
            phase_next  = PH_IDLE;
          end else begin
            scl_next   = 1'b1;
            phase_next = PH_WA_HIGH;
          end
        end
        PH_WA_HIGH: begin
          if (q_item.sda_in) begin
            status_next = ST_UNSTABLE;
            done_next   = 1'b1;
            phase_next  = PH_IDLE;
          end else begin
            scl_next   = 1'b0;
            phase_next = PH_FIN;
          end
        end
        PH_RD_HI: begin
          scl_next = 1'b1;
          if (q_item.sda_in) begin
            shift_byte_next[bit_index] = 1'b1;
          end
          if (bit_index == '0) begin
            phase_next = PH_RD_TAIL;
          end else begin
            bit_index_next = bit_index - 1'b1;
            phase_next     = PH_RD_LO;
          end
        end
        PH_RD_LO: begin
          scl_next   = 1'b0;
          phase_next = PH_RD_HI;
        end
        PH_RD_TAIL: begin
          scl_next   = 1'b0;
          phase_next = PH_RD_ACK;
        end
        PH_RD_ACK: begin
          sda_next   = !ack_choice;
          scl_next   = 1'b1;
          phase_next = PH_RD_REL;
        end
        PH_RD_REL: begin
          scl_next   = 1'b0;
          sda_next   = 1'b1;
          phase_next = PH_FIN;
        end
        PH_FIN: begin
          if (active == MODE_WAIT) begin
            status_next = ST_OK;
          end else if (active == MODE_READ) begin
            rx_hold_next = shift_byte;
          end
          done_next  = 1'b1;
          phase_next = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= AckTimeoutReset;
      phase       <= PH_IDLE;
      active      <= MODE_START;
      bit_index   <= LastBit;
      shift_byte  <= '0;
      poll_count  <= '0;
      scl         <= 1'b1;
      sda         <= 1'b1;
      ack_choice  <= 1'b0;
      status      <= ST_OK;
      rx_hold     <= '0;
      done        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ack_timeout <= cfg_data;
      end
      phase      <= phase_next;
      active     <= active_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      poll_count <= poll_count_next;
      scl        <= scl_next;
      sda        <= sda_next;
      ack_choice <= ack_choice_next;
      status     <= status_next;
      rx_hold    <= rx_hold_next;
      done       <= done_next;
      out_valid  <= out_valid_next;
    end
  end

  assign scl_level  = scl;
  assign sda_level  = sda;
  assign busy_res   = (phase != PH_IDLE);
  assign done_res   = done;
  assign rx_byte    = rx_hold;
  assign ack_status = status;

endmodule

@@ rtl/i2c_master_bit_engine.sv @@
// Each tick is taken into a small queue and then into the output register whenever the output side is not stalled.
// The sustained rate is one tick per clock cycle while the output side is not stalled, set by the bus engine step.
// The input is stalled only when the queue is full because the output side is stalled.
// Reset is synchronous and active high; it empties the queue, idles the engine,
// releases both bus lines and restores the acknowledge timeout to 100.
module i2c_master_bit_engine
  import i2cm_pkg::*;
#(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd_valid,
  input  logic [2:0]  mode,
  input  logic [7:0]  tx_byte,
  input  logic        send_ack,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  rx_byte,
  output logic [1:0]  ack_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  assign cfg_ready = 1'b1;

  i2cm_front #(
    .Depth(QDepth)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd_valid(cmd_valid),
    .mode     (mode),
    .tx_byte  (tx_byte),
    .send_ack (send_ack),
    .sda_in   (sda_in),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .rx_byte   (rx_byte),
    .ack_status(ack_status)
  );

endmodule

@@ rtl/i2cm_checker.sv @@
module i2cm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        scl_level,
  input logic        sda_level,
  input logic        busy_res,
  input logic        done_res,
  input logic [7:0]  rx_byte,
  input logic [1:0]  ack_status
);

  // A result held by a stalled consumer stays in place.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(busy_res) && $stable(done_res) && $stable(rx_byte) && $stable(ack_status))
    else $error("stalled result changed");

  // A finished command always leaves the engine idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ack_status != 2'd3)
    else $error("undefined acknowledge status");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind i2c_master_bit_engine i2cm_checker u_checker (.*);

@@ tb/tb_i2c_master_bit_engine.sv @@
module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int HoldCycles = 300;
  localparam int RandomTicks = 900;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic [1:0] status;
  } bus_levels_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        cmd_valid = 1'b0;
  logic [2:0]  mode = 3'd0;
  logic [7:0]  tx_byte = 8'd0;
  logic        send_ack = 1'b0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic [7:0]  rx_byte;
  logic [1:0]  ack_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [14:0] cfg_data = 15'd0;

  // Shadow copy of the engine state, advanced once per accepted tick.
  phase_t      eng_phase = PH_IDLE;
  logic [2:0]  eng_cmd = 3'd0;
  logic [2:0]  eng_bit = LastBit;
  logic [7:0]  eng_shift = 8'd0;
  logic [16:0] eng_polls = 17'd0;
  logic        eng_scl = 1'b1;
  logic        eng_sda = 1'b1;
  logic        eng_ack = 1'b0;
  status_t     eng_status = ST_OK;
  logic [7:0]  eng_rx = 8'd0;
  logic [14:0] eng_timeout = AckTimeoutReset;

  bus_levels_t pending_levels[$];

  int cycles = 0;
  int errors = 0;
  int n_checked = 0;
  int n_cmds = 0;
  int n_timeouts = 0;
  int n_unstable = 0;
  int work_ticks = 0;
  int burst_left = 0;
  int burst_max = 30;
  bit gaps_on = 1'b1;
  int hold_reqs = 0;

  i2c_master_bit_engine u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd_valid  (cmd_valid),
    .mode       (mode),
    .tx_byte    (tx_byte),
    .send_ack   (send_ack),
    .sda_in     (sda_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .busy_res   (busy_res),
    .done_res   (done_res),
    .rx_byte    (rx_byte),
    .ack_status (ack_status),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Run exceeded %0d cycles with %0d results outstanding.", CycleLimit,
               pending_levels.size());
      $display("simulation failed");
      $finish;
    end
  end

  function automatic bus_levels_t step_engine(tick_t t);
    bus_levels_t r;
    logic done;
    done = 1'b0;
    case (eng_phase)
      PH_IDLE: begin
        if (t.cmd_valid && t.mode <= MODE_READ) begin
          eng_cmd = t.mode;
          eng_bit = LastBit;
          case (t.mode)
            MODE_START: begin
              eng_scl = 1'b1;
              eng_sda = 1'b1;
              eng_phase = PH_ST_LOW;
            end
            MODE_STOP: begin
              eng_scl = 1'b1;
              eng_sda = 1'b0;
              eng_phase = PH_SP_END;
            end
            MODE_WRITE: begin
              eng_shift = t.tx_byte;
              eng_scl = 1'b0;
              eng_sda = t.tx_byte[LastBit];
              eng_phase = PH_WR_HI;
            end
            MODE_WAIT: begin
              eng_polls = {2'b00, eng_timeout};
              eng_phase = PH_WA_POLL;
            end
            default: begin
              eng_shift = 8'd0;
              eng_ack = t.send_ack;
              eng_scl = 1'b0;
              eng_phase = PH_RD_HI;
            end
          endcase
        end
      end
      PH_ST_LOW: begin
        eng_sda = 1'b0;
        eng_phase = PH_ST_END;
      end
      PH_ST_END: begin
        eng_scl = 1'b0;
        done = 1'b1;
        eng_phase = PH_IDLE;
      end
      PH_SP_END: begin
        eng_sda = 1'b1;
        done = 1'b1;
        eng_phase = PH_IDLE;
      end
      PH_WR_HI: begin
        eng_scl = 1'b1;
        if (eng_bit == 3'd0) begin
          eng_phase = PH_WR_END;
        end else begin
          eng_bit = eng_bit - 3'd1;
          eng_phase = PH_WR_LO;
        end
      end
      PH_WR_LO: begin
        eng_scl = 1'b0;
        eng_sda = eng_shift[eng_bit];
        eng_phase = PH_WR_HI;
      end
      PH_WR_END: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        done = 1'b1;
        eng_phase = PH_IDLE;
      end
      PH_WA_POLL: begin
        if (t.sda_in && eng_polls != 17'd0) begin
          eng_polls = eng_polls - 17'd1;
        end else if (eng_polls == 17'd0) begin
          eng_status = ST_TIMEOUT;
          done = 1'b1;
          eng_phase = PH_IDLE;
          n_timeouts++;
        end else begin
          eng_scl = 1'b1;
          eng_phase = PH_WA_HIGH;
        end
      end
      PH_WA_HIGH: begin
        if (t.sda_in) begin
          eng_status = ST_UNSTABLE;
          done = 1'b1;
          eng_phase = PH_IDLE;
          n_unstable++;
        end else begin
          eng_scl = 1'b0;
          eng_phase = PH_FIN;
        end
      end
      PH_RD_HI: begin
        eng_scl = 1'b1;
        if (t.sda_in) eng_shift[eng_bit] = 1'b1;
        if (eng_bit == 3'd0) begin
          eng_phase = PH_RD_TAIL;
        end else begin
          eng_bit = eng_bit - 3'd1;
          eng_phase = PH_RD_LO;
        end
      end
      PH_RD_LO: begin
        eng_scl = 1'b0;
        eng_phase = PH_RD_HI;
      end
      PH_RD_TAIL: begin
        eng_scl = 1'b0;
        eng_phase = PH_RD_ACK;
      end
      PH_RD_ACK: begin
        eng_sda = ~eng_ack;
        eng_scl = 1'b1;
        eng_phase = PH_RD_REL;
      end
      PH_RD_REL: begin
        eng_scl = 1'b0;
        eng_sda = 1'b1;
        eng_phase = PH_FIN;
      end
      PH_FIN: begin
        if (eng_cmd == MODE_WAIT) eng_status = ST_OK;
        else if (eng_cmd == MODE_READ) eng_rx = eng_shift;
        done = 1'b1;
        eng_phase = PH_IDLE;
      end
      default: begin
        eng_phase = PH_IDLE;
      end
    endcase
    r.scl = eng_scl;
    r.sda = eng_sda;
    r.busy = (eng_phase != PH_IDLE);
    r.done = done;
    r.rx = eng_rx;
    r.status = eng_status;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 20) begin
      $display("Mismatch on result %0d: %s is %0d, expected %0d.", n_checked, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    bus_levels_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected result, busy_res", busy_res, 0);
      end else begin
        want = pending_levels.pop_front();
        if (scl_level !== want.scl) report_mismatch("scl_level", scl_level, want.scl);
        if (sda_level !== want.sda) report_mismatch("sda_level", sda_level, want.sda);
        if (busy_res !== want.busy) report_mismatch("busy_res", busy_res, want.busy);
        if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
        if (rx_byte !== want.rx) report_mismatch("rx_byte", rx_byte, want.rx);
        if (ack_status !== want.status) report_mismatch("ack_status", ack_status, want.status);
      end
      n_checked++;
    end
  end

  // The receiver changes its stall pattern every so often; a requested hold-off
  // keeps it stalled for a long stretch regardless of the pattern.
  initial begin
    int holds_done;
    int hold_left;
    int pat_left;
    int pat_kind;
    holds_done = 0;
    hold_left = 0;
    pat_left = 0;
    pat_kind = 0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_reqs) begin
        holds_done = hold_reqs;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_kind = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 200);
        end
        pat_left--;
        case (pat_kind)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= (pat_left % 4 == 0);
        endcase
      end
    end
  end

  task automatic send_tick(tick_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = gaps_on ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd_valid <= t.cmd_valid;
    mode <= t.mode;
    tx_byte <= t.tx_byte;
    send_ack <= t.send_ack;
    sda_in <= t.sda_in;
    do @(posedge clk); while (in_stall);
    pending_levels.push_back(step_engine(t));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic set_ack_timeout(logic [14:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    eng_timeout = value;
  endtask

  task automatic idle_ticks(int n);
    tick_t t;
    repeat (n) begin
      t.cmd_valid = 1'($urandom_range(0, 1));
      t.mode = 3'(t.cmd_valid ? $urandom_range(5, 7) : $urandom_range(0, 7));
      t.tx_byte = 8'($urandom_range(0, 255));
      t.send_ack = 1'($urandom_range(0, 1));
      t.sda_in = 1'($urandom_range(0, 1));
      send_tick(t);
    end
  endtask

  // Issues one command and plays the slave until the engine is idle again.
  // For a read, data is the byte the slave returns; for wait-ack, the slave
  // holds SDA high for ack_after polls, and releases it at SCL high if unstable.
  task automatic run_cmd(logic [2:0] m, logic [7:0] data, bit ack, int ack_after,
                         bit unstable);
    tick_t t;
    int polls_seen;
    polls_seen = 0;
    t.cmd_valid = 1'b1;
    t.mode = m;
    t.tx_byte = data;
    t.send_ack = ack;
    t.sda_in = 1'($urandom_range(0, 1));
    send_tick(t);
    n_cmds++;
    work_ticks++;
    while (eng_phase != PH_IDLE) begin
      t.cmd_valid = 1'($urandom_range(0, 1));
      t.mode = 3'($urandom_range(0, 7));
      t.tx_byte = 8'($urandom_range(0, 255));
      t.send_ack = 1'($urandom_range(0, 1));
      t.sda_in = 1'($urandom_range(0, 1));
      case (eng_phase)
        PH_WA_POLL: begin
          t.sda_in = (polls_seen < ack_after);
          polls_seen++;
        end
        PH_WA_HIGH: t.sda_in = unstable;
        PH_RD_HI: t.sda_in = data[eng_bit];
        default: ;
      endcase
      send_tick(t);
      work_ticks++;
    end
  endtask

  task automatic random_wait_ack();
    int ack_after;
    if ($urandom_range(0, 3) == 0) ack_after = 0;
    else if (eng_timeout <= 40) ack_after = $urandom_range(0, eng_timeout + 2);
    else ack_after = $urandom_range(0, 40);
    run_cmd(MODE_WAIT, 8'd0, 1'b0, ack_after, $urandom_range(0, 3) == 0);
  endtask

  task automatic random_transfer(int n_bytes);
    run_cmd(MODE_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 1'b0);
    run_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 1'b0);
    random_wait_ack();
    for (int i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 4) == 0) idle_ticks($urandom_range(1, 3));
      if ($urandom_range(0, 1) == 0) begin
        run_cmd(MODE_WRITE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 1'b0);
        random_wait_ack();
      end else begin
        run_cmd(MODE_READ, 8'($urandom_range(0, 255)), i != n_bytes - 1, 0, 1'b0);
      end
    end
    run_cmd(MODE_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0, 1'b0);
  endtask

  task automatic test_directed();
    idle_ticks(3);
    run_cmd(MODE_START, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(MODE_WRITE, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(MODE_WRITE, 8'h00, 1'b1, 0, 1'b0);
    run_cmd(MODE_WRITE, 8'hA5, 1'b0, 0, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 3, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 2, 1'b1);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 1000, 1'b0);
    // The slave pulls SDA low exactly on the tick with no polls left.
    run_cmd(MODE_WAIT, 8'h00, 1'b0, AckTimeoutReset, 1'b0);
    run_cmd(MODE_READ, 8'h00, 1'b1, 0, 1'b0);
    run_cmd(MODE_READ, 8'hFF, 1'b0, 0, 1'b0);
    run_cmd(MODE_READ, 8'h5A, 1'b1, 0, 1'b0);
    run_cmd(3'd5, 8'hFF, 1'b1, 0, 1'b0);
    run_cmd(3'd6, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(3'd7, 8'hFF, 1'b1, 0, 1'b0);
    run_cmd(MODE_STOP, 8'h00, 1'b0, 0, 1'b0);
    idle_ticks(4);
  endtask

  task automatic test_timeout_settings();
    set_ack_timeout(15'd0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 5, 1'b0);
    set_ack_timeout(15'd1);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 0, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 1, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 2, 1'b0);
    set_ack_timeout(15'h7FFF);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 5, 1'b0);
    run_cmd(MODE_WAIT, 8'h00, 1'b0, 40, 1'b0);
    set_ack_timeout(AckTimeoutReset);
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_reqs++;
    random_transfer(3);
    random_transfer(2);
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int target;
    int next_cfg;
    target = work_ticks + RandomTicks;
    next_cfg = work_ticks + 200;
    while (work_ticks < target) begin
      if (work_ticks >= next_cfg) begin
        next_cfg = work_ticks + 200;
        case ($urandom_range(0, 4))
          0: set_ack_timeout(15'd0);
          1: set_ack_timeout(15'd1);
          2: set_ack_timeout(AckTimeoutReset);
          3: set_ack_timeout(15'h7FFF);
          default: set_ack_timeout(15'($urandom_range(2, 30)));
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
        burst_max = gaps_on ? $urandom_range(1, 40) : 200;
      end
      case ($urandom_range(0, 9))
        0: idle_ticks($urandom_range(1, 6));
        1, 2: run_cmd(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), $urandom_range(0, 6),
                      1'($urandom_range(0, 1)));
        default: random_transfer($urandom_range(1, 4));
      endcase
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_timeout_settings();
    test_backpressure();
    test_random();
    drain_results();
    repeat (10) @(posedge clk);
    $display("Checked %0d bus ticks from %0d commands, ack timeouts from 0 to 32767.",
             n_checked, n_cmds);
    $display("Wait-ack ended in %0d timeouts and %0d unstable acknowledges; %0d mismatches.",
             n_timeouts, n_unstable, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
